>>> design/mnc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the nearest-class classifier
package mnc_pkg;

  localparam logic [1:0] CMD_CENTRE = 2'd0;
  localparam logic [1:0] CMD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [63:0] DIST_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] DIST_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  class_select;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  class_id;
    logic [63:0] distance;
    logic        found;
    logic        final_res;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic first_j;
    logic last_j;
    logic first_i;
    logic last_i;
  } tok_t;

  typedef struct packed {
    logic [15:0] smp_j;
    logic [15:0] cen_j;
    logic [15:0] smp_i;
    logic [15:0] cen_i;
    logic [15:0] wgt;
  } rd_t;

endpackage

>>> design/mnc_store.sv
`timescale 1ns / 1ps
// centre, weight and sample memories with registered read ports
module mnc_store import mnc_pkg::*; #(
  parameter int SIDE = 4,
  parameter int CLASSES = 8,
  localparam int FEAT = SIDE * SIDE,
  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1,
  localparam int FW = (FEAT > 1) ? $clog2(FEAT) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  in_item_t      wr_i,
  input  logic [CW-1:0] cls_i,
  input  logic [FW-1:0] i_i,
  input  logic [FW-1:0] j_i,
  output rd_t           rd_o
);

  logic [15:0] smp_mem [FEAT];
  logic [15:0] cen_mem [CLASSES][FEAT];
  logic [15:0] wgt_mem [CLASSES][FEAT][FEAT];

  logic          cls_ok, row_ok, col_ok;
  logic          cen_we, wgt_we, smp_we;
  logic [CW-1:0] wcls;
  logic [FW-1:0] wrow, wcol;
  rd_t           rd_q;

  always_comb begin
    cls_ok = int'(wr_i.class_select) < CLASSES;
    row_ok = int'(wr_i.row) < FEAT;
    col_ok = int'(wr_i.col) < FEAT;
    wcls   = CW'(wr_i.class_select);
    wrow   = FW'(wr_i.row);
    wcol   = FW'(wr_i.col);
    cen_we = 1'b0;
    wgt_we = 1'b0;
    smp_we = 1'b0;
    unique case (wr_i.cmd)
      CMD_CENTRE: cen_we = wr_en_i && cls_ok && row_ok;
      CMD_WEIGHT: wgt_we = wr_en_i && cls_ok && row_ok && col_ok;
      CMD_SAMPLE: smp_we = wr_en_i && row_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[wrow] <= wr_i.value;
    end
    if (cen_we) begin
      cen_mem[wcls][wrow] <= wr_i.value;
    end
    if (wgt_we) begin
      wgt_mem[wcls][wrow][wcol] <= wr_i.value;
    end
    rd_q.smp_j <= smp_mem[j_i];
    rd_q.smp_i <= smp_mem[i_i];
    rd_q.cen_j <= cen_mem[cls_i][j_i];
    rd_q.cen_i <= cen_mem[cls_i][i_i];
    rd_q.wgt   <= wgt_mem[cls_i][j_i][i_i];
  end

  assign rd_o = rd_q;

endmodule

>>> design/mnc_datapath.sv
`timescale 1ns / 1ps
// pipelined multiply-accumulate for the quadratic form of one class
module mnc_datapath import mnc_pkg::*; #(
  parameter int SIDE = 4,
  localparam int FEAT = SIDE * SIDE,
  localparam int TW = 33 + $clog2(FEAT),
  localparam int MW = TW + 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tok_t        tok_i,
  input  rd_t         rd_i,
  output logic [63:0] q_o,
  output logic        done_o
);

  tok_t tok1_q, tok2_q, tok3_q, tok4_q, tok5_q;
  logic done_q;

  logic signed [16:0]   dj_q, di_q, di3_q, di4_q;
  logic signed [15:0]   w2_q;
  logic signed [32:0]   p_q;
  logic signed [TW-1:0] t_q, t_sum, tf_q;
  logic signed [MW-1:0] m_q;
  logic signed [63:0]   q_q, q_base, m_ext;
  logic        [64:0]   q_sum;
  logic        [63:0]   q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
      tok3_q <= '0;
      tok4_q <= '0;
      tok5_q <= '0;
      done_q <= 1'b0;
    end else begin
      tok1_q <= tok_i;
      tok2_q <= tok1_q;
      tok3_q <= tok2_q;
      tok4_q <= {tok3_q.valid && tok3_q.last_j, tok3_q.first_j, tok3_q.last_j,
                 tok3_q.first_i, tok3_q.last_i};
      tok5_q <= tok4_q;
      done_q <= tok5_q.valid && tok5_q.last_i;
    end
  end

  // difference, product, row sum, form term, then saturating accumulation
  always_comb begin
    t_sum  = (tok3_q.first_j ? '0 : t_q) + TW'(p_q);
    q_base = tok5_q.first_i ? '0 : q_q;
    m_ext  = 64'(m_q);
    q_sum  = {q_base[63], q_base} + {m_ext[63], m_ext};
    if (q_sum[64] != q_sum[63]) begin
      q_d = q_sum[64] ? DIST_MIN : DIST_MAX;
    end else begin
      q_d = q_sum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dj_q  <= $signed({rd_i.smp_j[15], rd_i.smp_j}) - $signed({rd_i.cen_j[15], rd_i.cen_j});
    di_q  <= $signed({rd_i.smp_i[15], rd_i.smp_i}) - $signed({rd_i.cen_i[15], rd_i.cen_i});
    w2_q  <= $signed(rd_i.wgt);
    p_q   <= dj_q * w2_q;
    di3_q <= di_q;
    if (tok3_q.valid) begin
      t_q <= t_sum;
    end
    if (tok3_q.valid && tok3_q.last_j) begin
      tf_q  <= t_sum;
      di4_q <= di3_q;
    end
    m_q <= tf_q * di4_q;
    if (tok5_q.valid) begin
      q_q <= q_d;
    end
  end

  assign q_o    = q_q;
  assign done_o = done_q;

endmodule

>>> design/mahalanobis_nearest_class_core.sv
`timescale 1ns / 1ps
// top level of the minimum quadratic-distance classifier
//
// input channel: one transaction per element, cmd selects a centre load,
// a weight load or a sample element; loads and plain sample elements
// give no result.
// a sample element with last set starts a classification run. for every
// class the core streams SIDE^4 weight products through one multiply-
// accumulate pipeline fed by the weight memory read port, one per cycle;
// each class result is emitted before the next class is issued, and
// the decision transaction follows the last class result.
// output channel: one transaction per class with its distance, then one
// decision transaction with final_res set.
// while a run is busy in_ready_o is low; between runs loads are taken even
// while a result still waits in the output register.
// a stalled receiver holds the output register and the run pauses before
// the next class result until it is taken.
// reset clears control state and the best-so-far registers; memory
// contents are undefined until loaded.
module mahalanobis_nearest_class_core import mnc_pkg::*; #(
  parameter int SIDE = 4,
  parameter int CLASSES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int FEAT = SIDE * SIDE;
  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int FW = (FEAT > 1) ? $clog2(FEAT) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_WAIT   = 5'b00100,
    S_EMIT   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] c_q, c_d;
  logic [FW-1:0] i_q, i_d, j_q, j_d;
  logic [63:0]   best_dist_q, best_dist_d;
  logic [2:0]    best_cls_q, best_cls_d;
  logic          best_found_q, best_found_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic        in_acc, start, out_free, j_last, i_last, c_last, ok, better, done;
  logic [63:0] q;
  tok_t        tok;
  rd_t         rd;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && (in_data_i.cmd == CMD_SAMPLE) && in_data_i.last;
  assign out_free   = !out_valid_q || out_ready_i;
  assign j_last     = (j_q == FW'(FEAT - 1));
  assign i_last     = (i_q == FW'(FEAT - 1));
  assign c_last     = (c_q == CW'(CLASSES - 1));
  assign ok         = !q[63];
  assign better     = ok && (!best_found_q || ($signed(q) < $signed(best_dist_q)));

  always_comb begin
    tok.valid   = (state_q == S_ISSUE);
    tok.first_j = (j_q == '0);
    tok.last_j  = j_last;
    tok.first_i = (i_q == '0);
    tok.last_i  = i_last;
  end

  mnc_store #(
    .SIDE    (SIDE),
    .CLASSES (CLASSES)
  ) u_store (
    .clk_i   (clk_i),
    .wr_en_i (in_acc),
    .wr_i    (in_data_i),
    .cls_i   (c_q),
    .i_i     (i_q),
    .j_i     (j_q),
    .rd_o    (rd)
  );

  mnc_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .rd_i   (rd),
    .q_o    (q),
    .done_o (done)
  );

  always_comb begin
    state_d      = state_q;
    c_d          = c_q;
    i_d          = i_q;
    j_d          = j_q;
    best_dist_d  = best_dist_q;
    best_cls_d   = best_cls_q;
    best_found_d = best_found_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d      = S_ISSUE;
          c_d          = '0;
          i_d          = '0;
          j_d          = '0;
          best_dist_d  = DIST_MAX;
          best_cls_d   = '0;
          best_found_d = 1'b0;
        end
      end
      S_ISSUE: begin
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            state_d = S_WAIT;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = 1'b0;
          out_d.class_id  = 3'(c_q);
          out_d.distance  = q;
          out_d.found     = ok;
          out_d.final_res = 1'b0;
          if (better) begin
            best_dist_d  = q;
            best_cls_d   = 3'(c_q);
            best_found_d = 1'b1;
          end
          if (c_last) begin
            state_d = S_DECIDE;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_ISSUE;
          end
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = 1'b1;
          out_d.class_id  = best_cls_q;
          out_d.distance  = best_dist_q;
          out_d.found     = best_found_q;
          out_d.final_res = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      c_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      best_dist_q  <= DIST_MAX;
      best_cls_q   <= '0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      c_q          <= c_d;
      i_q          <= i_d;
      j_q          <= j_d;
      best_dist_q  <= best_dist_d;
      best_cls_q   <= best_cls_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/mnc_checker.sv
`timescale 1ns / 1ps
// port-level checks of the classifier and their bind to the top level
module mnc_checker import mnc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the last sample element starts a run that blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd == CMD_SAMPLE) && in_data_i.last
    |=> !in_ready_o)
    else $error("input not blocked after last sample element");

  // a per-class result only waits while its run is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.final_res |-> !in_ready_o)
    else $error("class result pending outside a run");

  // a per-class distance flagged valid is nonnegative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind && out_data_o.found |-> !out_data_o.distance[63])
    else $error("negative distance flagged as found");

endmodule

bind mahalanobis_nearest_class_core mnc_checker u_mnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/mahalanobis_nearest_class_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the nearest-class core, with its own distance predictor
module mahalanobis_nearest_class_core_tb import mnc_pkg::*;;

  localparam int SIDE = 4;
  localparam int CLASSES = 8;
  localparam int FEAT = SIDE * SIDE;
  localparam int RUN_CYCLES = CLASSES * (SIDE ** 4 + 8);
  localparam int TAIL_CYCLES = RUN_CYCLES + 100;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 180;
  localparam int MIN_RUNS = 6;
  localparam int HOLD_CYCLES = 3000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic KIND_DISTANCE = 1'b0;
  localparam logic KIND_DECISION = 1'b1;
  localparam logic [15:0] ONE_Q12 = 16'h1000;
  localparam logic [15:0] MINUS_ONE_Q12 = 16'hF000;
  localparam logic [15:0] VALUE_MAX = 16'h7FFF;
  localparam logic [15:0] VALUE_MIN = 16'h8000;

  class distance_board;
    logic signed [15:0] centre_mem [CLASSES][FEAT];
    logic signed [15:0] weight_mem [CLASSES][FEAT][FEAT];
    logic signed [15:0] sample_mem [FEAT];
    out_item_t due_results [$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic signed [63:0] class_form(int c);
      logic signed [16:0] diff [FEAT];
      logic signed [63:0] acc, part, sum;
      int i, j;
      acc = '0;
      for (i = 0; i < FEAT; i++) diff[i] = sample_mem[i] - centre_mem[c][i];
      for (i = 0; i < FEAT; i++) begin
        part = '0;
        for (j = 0; j < FEAT; j++) part = part + diff[j] * weight_mem[c][j][i];
        part = part * diff[i];
        sum = acc + part;
        if (acc[63] == part[63] && sum[63] != acc[63]) begin
          sum = acc[63] ? DIST_MIN : DIST_MAX;
        end
        acc = sum;
      end
      return acc;
    endfunction

    function void note_transaction(in_item_t item);
      logic signed [63:0] best, q;
      logic [2:0] best_class;
      logic best_found;
      out_item_t res;
      int c;
      case (item.cmd)
        CMD_CENTRE: begin
          if (int'(item.class_select) < CLASSES && int'(item.row) < FEAT) begin
            centre_mem[item.class_select][item.row] = item.value;
          end
        end
        CMD_WEIGHT: begin
          if (int'(item.class_select) < CLASSES && int'(item.row) < FEAT &&
              int'(item.col) < FEAT) begin
            weight_mem[item.class_select][item.row][item.col] = item.value;
          end
        end
        CMD_SAMPLE: begin
          if (int'(item.row) < FEAT) sample_mem[item.row] = item.value;
          if (item.last) begin
            best = DIST_MAX;
            best_class = '0;
            best_found = 1'b0;
            for (c = 0; c < CLASSES; c++) begin
              q = class_form(c);
              res.kind = KIND_DISTANCE;
              res.class_id = 3'(c);
              res.distance = q;
              res.found = !q[63];
              res.final_res = 1'b0;
              due_results = {due_results, res};
              if (!q[63] && (!best_found || q < best)) begin
                best = q;
                best_class = 3'(c);
                best_found = 1'b1;
              end
            end
            res.kind = KIND_DECISION;
            res.class_id = best_class;
            res.distance = best;
            res.found = best_found;
            res.final_res = 1'b1;
            due_results = {due_results, res};
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_transaction(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result: kind %0d class %0d distance %0d found %0d final %0d",
                   got.kind, got.class_id, $signed(got.distance), got.found, got.final_res);
        end
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch: expected kind %0d class %0d distance %0d found %0d final %0d",
                   want.kind, want.class_id, $signed(want.distance), want.found,
                   want.final_res);
          $display("                 actual   kind %0d class %0d distance %0d found %0d final %0d",
                   got.kind, got.class_id, $signed(got.distance), got.found, got.final_res);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  distance_board board;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int random_items = 0;
  int runs_started = 0;
  int cycle_count = 0;

  mahalanobis_nearest_class_core #(
    .SIDE(SIDE),
    .CLASSES(CLASSES)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("mahalanobis_nearest_class_core_tb failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) board.check_transaction(out_data_o);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, int cls, int row, int col,
                                         logic [15:0] value, logic last);
    in_item_t item;
    item.cmd = cmd;
    item.class_select = 3'(cls);
    item.row = 4'(row);
    item.col = 4'(col);
    item.value = value;
    item.last = last;
    return item;
  endfunction

  function automatic logic [15:0] pick_value(int spread);
    case ($urandom_range(0, 9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2, 3, 4: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transaction(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_scene(input bit well_formed_only);
    int n, k, r, c, tmp;
    int order [FEAT];
    if (well_formed_only || $urandom_range(0, 99) < 75) begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        c = $urandom_range(0, CLASSES - 1);
        r = $urandom_range(0, FEAT - 1);
        if ($urandom_range(0, 2) == 0) begin
          send_item(make_item(CMD_CENTRE, c, r, $urandom_range(0, FEAT - 1),
                              pick_value(2048), 1'($urandom_range(0, 1))));
        end else if ($urandom_range(0, 1) == 0) begin
          // diagonal weight, kept nonnegative
          send_item(make_item(CMD_WEIGHT, c, r, r, 16'($urandom_range(0, 8191)),
                              1'($urandom_range(0, 1))));
        end else begin
          send_item(make_item(CMD_WEIGHT, c, r, $urandom_range(0, FEAT - 1),
                              pick_value(1024), 1'($urandom_range(0, 1))));
        end
        random_items++;
      end
      for (k = 0; k < FEAT; k++) order[k] = k;
      for (k = FEAT - 1; k > 0; k--) begin
        r = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[r];
        order[r] = tmp;
      end
      for (k = 0; k < FEAT; k++) begin
        send_item(make_item(CMD_SAMPLE, $urandom_range(0, CLASSES - 1), order[k],
                            $urandom_range(0, FEAT - 1), pick_value(2048), k == FEAT - 1));
        random_items++;
      end
      runs_started++;
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: begin
            send_item(make_item(CMD_UNUSED, $urandom_range(0, CLASSES - 1),
                                $urandom_range(0, FEAT - 1), $urandom_range(0, FEAT - 1),
                                16'($urandom), 1'($urandom_range(0, 1))));
          end
          1: begin
            send_item(make_item(CMD_CENTRE, $urandom_range(0, CLASSES - 1),
                                $urandom_range(0, FEAT - 1), $urandom_range(0, FEAT - 1),
                                pick_value(2048), 1'b1));
            random_items++;
          end
          default: begin
            send_item(make_item(CMD_SAMPLE, $urandom_range(0, CLASSES - 1),
                                $urandom_range(0, FEAT - 1), $urandom_range(0, FEAT - 1),
                                pick_value(2048), 1'b0));
            random_items++;
          end
        endcase
      end
      // partial sample vector, classified with stale entries
      if ($urandom_range(0, 1) == 0) begin
        send_item(make_item(CMD_SAMPLE, $urandom_range(0, CLASSES - 1),
                            $urandom_range(0, FEAT - 1), $urandom_range(0, FEAT - 1),
                            pick_value(2048), 1'b1));
        random_items++;
        runs_started++;
      end
    end
  endtask

  initial begin
    int c, j, i, phase, cur_phase;
    board = new();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every centre and weight entry: zero centres, weights of minus one on the diagonal
    for (c = 0; c < CLASSES; c++) begin
      for (j = 0; j < FEAT; j++) begin
        send_item(make_item(CMD_CENTRE, c, j, $urandom_range(0, FEAT - 1), '0,
                            1'($urandom_range(0, 1))));
      end
    end
    for (c = 0; c < CLASSES; c++) begin
      for (j = 0; j < FEAT; j++) begin
        for (i = 0; i < FEAT; i++) begin
          send_item(make_item(CMD_WEIGHT, c, j, i, (i == j) ? MINUS_ONE_Q12 : '0,
                              1'($urandom_range(0, 1))));
        end
      end
    end

    // every form negative, so no class is chosen
    for (j = 0; j < FEAT; j++) begin
      send_item(make_item(CMD_SAMPLE, $urandom_range(0, CLASSES - 1), j,
                          $urandom_range(0, FEAT - 1),
                          (j == 0) ? VALUE_MAX : (j == 1) ? VALUE_MIN :
                          (j < 4) ? 16'($urandom_range(1, 32767)) : '0,
                          j == FEAT - 1));
    end

    // two identical positive classes tie, the lower one wins; widest difference
    for (j = 0; j < 4; j++) begin
      send_item(make_item(CMD_WEIGHT, 2, j, j, ONE_Q12, 1'b0));
      send_item(make_item(CMD_WEIGHT, 5, j, j, ONE_Q12, 1'b1));
    end
    send_item(make_item(CMD_CENTRE, 2, 1, 0, VALUE_MAX, 1'b0));
    send_item(make_item(CMD_CENTRE, 5, 1, 0, VALUE_MAX, 1'b1));
    send_item(make_item(CMD_UNUSED, 7, 15, 15, VALUE_MIN, 1'b1));
    send_item(make_item(CMD_SAMPLE, 7, 0, 15, VALUE_MAX, 1'b1));

    // receiver holds off while the sender keeps offering
    hold_request = HOLD_CYCLES;
    random_scene(1'b1);
    random_scene(1'b1);
    wait_drained();

    cur_phase = 0;
    while (random_items < RANDOM_ITEMS || runs_started < MIN_RUNS) begin
      phase = random_items * 4 / RANDOM_ITEMS;
      if (phase > 3) phase = 3;
      if (phase != cur_phase) begin
        wait_drained();
        cur_phase = phase;
        case (phase)
          1: begin
            src_idle_pct = 73;
            sink_stall_pct = 0;
          end
          2: begin
            src_idle_pct = 0;
            sink_stall_pct = 73;
          end
          default: begin
            src_idle_pct = 20;
            sink_stall_pct = 20;
          end
        endcase
      end
      random_scene(1'b0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("mahalanobis_nearest_class_core_tb passed");
    end else begin
      $display("mahalanobis_nearest_class_core_tb failed");
    end
    $finish;
  end

endmodule
